// ===== rtl/unix_to_fat_timestamp_core_assert.svh =====
// Assertion macros used by the RTL controller. Clock is clk, reset is rst_n.
`ifndef UNIX_TO_FAT_TIMESTAMP_CORE_ASSERT_SVH
`define UNIX_TO_FAT_TIMESTAMP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define UTFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define UTFT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define UTFT_ASSERT(lbl, prop, msg)

`define UTFT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/utft_pkg.sv =====
package utft_pkg;

  localparam logic [31:0] BASE_SECONDS = 32'd315532800;
  localparam logic [17:0] SEC_PER_DAY  = 18'd86400;
  localparam logic [17:0] SEC_PER_HOUR = 18'd3600;
  localparam logic [17:0] SEC_PER_MIN  = 18'd60;
  localparam logic [6:0]  YOFF_MAX     = 7'd127;
  localparam logic [6:0]  YOFF_2100    = 7'd120;
  localparam logic [15:0] DATE_FLOOR   = 16'h0021;
  localparam logic [3:0]  MONTHS       = 4'd12;
  localparam logic [3:0]  MONTH_FEB    = 4'd1;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_NORMAL  = 9'd365;

  // Rounded-up reciprocals, exact over the operand ranges in use
  localparam logic [25:0] RECIP_DAY    = 26'd50903317;  // 2^35 / 675, seconds >> 7 below 2^25
  localparam logic [17:0] RECIP_HOUR   = 18'd149131;    // 2^29 / 3600, operand below 2^17
  localparam logic [12:0] RECIP_MIN    = 13'd4370;      // 2^18 / 60, operand below 2^12

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_Q,
    ST_DAY_R,
    ST_HOUR_Q,
    ST_HOUR_R,
    ST_MIN_Q,
    ST_MIN_R,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUOT,
    OP_REM,
    OP_YEAR,
    OP_MONTH,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    DV_DAY,
    DV_HOUR,
    DV_MIN
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    div_sel_t div;
  } cmd_t;

  typedef struct packed {
    logic below_base;
    logic year_fits;
    logic month_fits;
  } status_t;

  // 1980 is a leap year, so only the offset's low bits and 2100 matter up to 2107
  function automatic logic yoff_leap(input logic [6:0] yoff);
    yoff_leap = (yoff[1:0] == 2'b00) && (yoff != YOFF_2100);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage

// ===== rtl/utft_in_if.sv =====
interface utft_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

// ===== rtl/utft_out_if.sv =====
interface utft_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fat_date;
  logic [15:0] fat_time;

  modport source (output valid, output fat_date, output fat_time, input ready);
  modport sink (input valid, input fat_date, input fat_time, output ready);
endinterface

// ===== rtl/utft_datapath.sv =====
module utft_datapath (
  input  logic               clk,
  input  logic [31:0]        epoch_seconds,
  input  utft_pkg::cmd_t     cmd,
  output utft_pkg::status_t  status,
  output logic [15:0]        fat_date,
  output logic [15:0]        fat_time
);

  logic [31:0] num_r, num_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [6:0]  yoff_r, yoff_nxt;
  logic [3:0]  month_r, month_nxt;
  logic        pre_r, pre_nxt;
  logic [15:0] date_r, date_nxt;
  logic [15:0] time_r, time_nxt;

  logic [31:0] diff;
  logic [50:0] day_prod;
  logic [33:0] hour_prod;
  logic [23:0] min_prod;
  logic [31:0] day_back;
  logic [17:0] hour_back;
  logic [17:0] min_back;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign diff  = epoch_seconds - utft_pkg::BASE_SECONDS;
  assign leap  = utft_pkg::yoff_leap(yoff_r);
  assign ylen  = leap ? utft_pkg::DAYS_LEAP : utft_pkg::DAYS_NORMAL;
  assign mlen  = utft_pkg::month_len(month_r, leap);

  // seconds / 86400 is (seconds >> 7) / 675
  assign day_prod  = {26'd0, num_r[31:7]} * {25'd0, utft_pkg::RECIP_DAY};
  assign hour_prod = {17'd0, num_r[16:0]} * {16'd0, utft_pkg::RECIP_HOUR};
  assign min_prod  = {12'd0, num_r[11:0]} * {11'd0, utft_pkg::RECIP_MIN};
  assign day_back  = {16'd0, days_r} * {14'd0, utft_pkg::SEC_PER_DAY};
  assign hour_back = {13'd0, hour_r} * utft_pkg::SEC_PER_HOUR;
  assign min_back  = {12'd0, min_r} * utft_pkg::SEC_PER_MIN;

  assign status.below_base = (epoch_seconds < utft_pkg::BASE_SECONDS);
  assign status.year_fits  = (days_r < {7'd0, ylen}) || (yoff_r == utft_pkg::YOFF_MAX);
  assign status.month_fits = (days_r < {11'd0, mlen}) || (month_r == utft_pkg::MONTHS);

  always_comb begin
    num_nxt   = num_r;
    days_nxt  = days_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    yoff_nxt  = yoff_r;
    month_nxt = month_r;
    pre_nxt   = pre_r;
    date_nxt  = date_r;
    time_nxt  = time_r;
    case (cmd.op)
      utft_pkg::OP_LOAD: begin
        num_nxt   = diff;
        pre_nxt   = status.below_base;
        yoff_nxt  = '0;
        month_nxt = '0;
      end
      utft_pkg::OP_QUOT: begin
        case (cmd.div)
          utft_pkg::DV_DAY:  days_nxt = day_prod[50:35];
          utft_pkg::DV_HOUR: hour_nxt = hour_prod[33:29];
          utft_pkg::DV_MIN:  min_nxt  = min_prod[23:18];
          default: begin
          end
        endcase
      end
      utft_pkg::OP_REM: begin
        case (cmd.div)
          utft_pkg::DV_DAY:  num_nxt = num_r - day_back;
          utft_pkg::DV_HOUR: num_nxt = num_r - {14'd0, hour_back};
          utft_pkg::DV_MIN:  num_nxt = num_r - {14'd0, min_back};
          default: begin
          end
        endcase
      end
      utft_pkg::OP_YEAR: begin
        days_nxt = days_r - {7'd0, ylen};
        yoff_nxt = yoff_r + 7'd1;
      end
      utft_pkg::OP_MONTH: begin
        days_nxt  = days_r - {11'd0, mlen};
        month_nxt = month_r + 4'd1;
      end
      utft_pkg::OP_OUT: begin
        if (pre_r) begin
          date_nxt = utft_pkg::DATE_FLOOR;
          time_nxt = '0;
        end else begin
          date_nxt = {yoff_r, 4'(month_r + 4'd1), 5'(days_r[4:0] + 5'd1)};
          time_nxt = {hour_r, min_r, num_r[5:1]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    days_r  <= days_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    yoff_r  <= yoff_nxt;
    month_r <= month_nxt;
    pre_r   <= pre_nxt;
    date_r  <= date_nxt;
    time_r  <= time_nxt;
  end

  assign fat_date = date_r;
  assign fat_time = time_r;

endmodule

// ===== rtl/utft_ctrl.sv =====
`include "unix_to_fat_timestamp_core_assert.svh"

module utft_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  utft_pkg::status_t  status,
  output utft_pkg::cmd_t     cmd
);

  utft_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= utft_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.op    = utft_pkg::OP_NONE;
    cmd.div   = utft_pkg::DV_DAY;
    case (state_r)
      utft_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = utft_pkg::OP_LOAD;
          state_nxt = status.below_base ? utft_pkg::ST_FINISH : utft_pkg::ST_DAY_Q;
        end
      end
      utft_pkg::ST_DAY_Q: begin
        cmd.op    = utft_pkg::OP_QUOT;
        cmd.div   = utft_pkg::DV_DAY;
        state_nxt = utft_pkg::ST_DAY_R;
      end
      utft_pkg::ST_DAY_R: begin
        cmd.op    = utft_pkg::OP_REM;
        cmd.div   = utft_pkg::DV_DAY;
        state_nxt = utft_pkg::ST_HOUR_Q;
      end
      utft_pkg::ST_HOUR_Q: begin
        cmd.op    = utft_pkg::OP_QUOT;
        cmd.div   = utft_pkg::DV_HOUR;
        state_nxt = utft_pkg::ST_HOUR_R;
      end
      utft_pkg::ST_HOUR_R: begin
        cmd.op    = utft_pkg::OP_REM;
        cmd.div   = utft_pkg::DV_HOUR;
        state_nxt = utft_pkg::ST_MIN_Q;
      end
      utft_pkg::ST_MIN_Q: begin
        cmd.op    = utft_pkg::OP_QUOT;
        cmd.div   = utft_pkg::DV_MIN;
        state_nxt = utft_pkg::ST_MIN_R;
      end
      utft_pkg::ST_MIN_R: begin
        cmd.op    = utft_pkg::OP_REM;
        cmd.div   = utft_pkg::DV_MIN;
        state_nxt = utft_pkg::ST_YEAR;
      end
      utft_pkg::ST_YEAR: begin
        if (status.year_fits) state_nxt = utft_pkg::ST_MONTH;
        else cmd.op = utft_pkg::OP_YEAR;
      end
      utft_pkg::ST_MONTH: begin
        if (status.month_fits) state_nxt = utft_pkg::ST_FINISH;
        else cmd.op = utft_pkg::OP_MONTH;
      end
      utft_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.op    = utft_pkg::OP_OUT;
          state_nxt = utft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = utft_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_load = (cmd.op == utft_pkg::OP_OUT);

  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  `UTFT_NEVER(a_no_overwrite, out_load && out_valid_r && !out_ready, "result overwritten")
  `UTFT_ASSERT(a_accept_starts, (in_valid && in_ready) |=> !in_ready, "beat did not start work")
  `UTFT_ASSERT(a_out_held, (out_valid_r && !out_ready) |=> out_valid_r, "result dropped")

endmodule

// ===== rtl/unix_to_fat_timestamp_core.sv =====
// Channel  | Dir | Handshake   | Payload
// in_ch    | in  | valid/ready | epoch_seconds[31:0]
// out_ch   | out | valid/ready | fat_date[15:0], fat_time[15:0]
//
// One beat at a time. A beat goes through the accept, three reciprocal-multiply quotient
// and remainder pairs, the year and month walks and the output load; inputs before 1980
// go from the accept straight to the output load.
// Synchronous active-low reset clears the controller and the output valid.
// A new beat is taken while a result still waits on out_ch; the finished result then
// holds until the output register frees.
module unix_to_fat_timestamp_core (
  input logic       clk,
  input logic       rst_n,
  utft_in_if.sink   in_ch,
  utft_out_if.source out_ch
);

  utft_pkg::cmd_t    cmd;
  utft_pkg::status_t status;

  utft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  utft_datapath u_datapath (
    .clk           (clk),
    .epoch_seconds (in_ch.epoch_seconds),
    .cmd           (cmd),
    .status        (status),
    .fat_date      (out_ch.fat_date),
    .fat_time      (out_ch.fat_time)
  );

endmodule
